[hw/rtl/round_robin_turn_token_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the round-robin turn token core
// Shorthand for the clocked, reset-qualified checks used in the core.
// ---------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TURN_TOKEN_CORE_ASSERT_SVH
`define ROUND_ROBIN_TURN_TOKEN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define RRTT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("turn token core check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define RRTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("turn token core check failed");

`endif

[hw/rtl/rrtt_pkg.sv]
// ---------------------------------------------------------------------------
// Round-robin turn token package
// Sizes, command codes and error codes shared by the turn token core.
// ---------------------------------------------------------------------------
package rrtt_pkg;

    // Number of participant slots (supported range 2 to 16).
    localparam int SLOTS = 16;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SLOT_W = 4;
    localparam int CMD_W  = 3;
    localparam int ERR_W  = 2;
    localparam int CMP_W  = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_REMOVE  = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_START   = 3'd3,
        CMD_ADVANCE = 3'd4,
        CMD_QUERY   = 3'd5
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK          = 2'd0,
        ERR_FULL        = 2'd1,
        ERR_NOT_ALLOC   = 2'd2,
        ERR_NONE_ACTIVE = 2'd3
    } err_t;

    // Result payload, first field in the highest bits.
    typedef struct packed {
        err_t              error;
        logic              is_turn;
        logic              running;
        logic [SLOT_W-1:0] slot_out;
    } result_t;

endpackage

[hw/rtl/round_robin_turn_token_core.sv]
// ---------------------------------------------------------------------------
// Round-robin turn token core
// Hands a single turn token among registered slots in round-robin order.
// ---------------------------------------------------------------------------
// The core accepts one command transaction per clock cycle while s_tready is
// high and returns exactly one result transaction for each, in order, through
// the input register and then the result register. Each command is fully
// evaluated by a single combinational pass from the input register to the
// result register, including the rotated find-first search over the active
// bitmap used by advance, so that pass sets the cycle time and the throughput
// stays at one command per cycle without an output stall. A stall on the
// output side holds the result register, then the input register, and only
// then drops s_tready. Commands are insert, remove, stop, start, advance and
// query; the error field reports a full table, an unallocated slot, or an
// advance with no active slot, and in each of those cases the state is left
// unchanged. Command codes six and seven report the status and change nothing.
// ---------------------------------------------------------------------------
module round_robin_turn_token_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0 up: command[2:0], slot_id[6:3], zero pad[7].
    input  logic [rrtt_pkg::IN_TDATA_W-1:0]     s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0 up: slot_out[3:0], running[4], is_turn[5], error[7:6].
    output logic [rrtt_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // Input register stage.
    logic                              in_valid_reg;
    logic [rrtt_pkg::CMD_W-1:0]        in_cmd_reg;
    logic [rrtt_pkg::SLOT_W-1:0]       in_id_reg;

    // Result register stage.
    logic                              out_valid_reg;
    rrtt_pkg::result_t                 out_data_reg;

    // Scheduler state.
    logic [rrtt_pkg::SLOTS-1:0]        active_map_reg;
    logic [rrtt_pkg::SLOTS-1:0]        active_map_next;
    logic [rrtt_pkg::CNT_W-1:0]        alloc_count_reg;
    logic [rrtt_pkg::CNT_W-1:0]        alloc_count_next;
    logic [rrtt_pkg::IDX_W-1:0]        holder_index_reg;
    logic [rrtt_pkg::IDX_W-1:0]        holder_index_next;
    logic                              holder_running_reg;
    logic                              holder_running_next;
    logic [rrtt_pkg::IDX_W-1:0]        saved_index_reg;
    logic [rrtt_pkg::IDX_W-1:0]        saved_index_next;
    logic                              saved_running_reg;
    logic                              saved_running_next;

    rrtt_pkg::result_t                 result_next;

    // Handshake control.
    logic                              out_free;
    logic                              do_work;

    // Advance search.
    logic [rrtt_pkg::IDX_W-1:0]        search_start;
    logic [2*rrtt_pkg::SLOTS-1:0]      active_dbl;
    logic [rrtt_pkg::SLOTS-1:0]        active_rot;
    logic [rrtt_pkg::IDX_W-1:0]        found_off;
    logic                              found_any;
    logic [rrtt_pkg::IDX_W:0]          found_sum;
    logic [rrtt_pkg::IDX_W-1:0]        found_idx;

    // Slot id checks.
    logic [rrtt_pkg::CMP_W-1:0]        id_wide;
    logic                              id_valid;
    logic [rrtt_pkg::IDX_W-1:0]        id_idx;

    // The result register frees up when it is empty or being drained; the
    // input register moves forward whenever the result register can take it.
    assign out_free = !out_valid_reg || m_tready;
    assign do_work  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // While running, the search starts just past the holder and wraps;
    // while stopped it starts at slot zero.
    always_comb
    begin
        if (!holder_running_reg)
        begin
            search_start = '0;
        end
        else if (holder_index_reg == rrtt_pkg::IDX_W'(rrtt_pkg::SLOTS - 1))
        begin
            search_start = '0;
        end
        else
        begin
            search_start = holder_index_reg + rrtt_pkg::IDX_W'(1);
        end
    end

    // Rotate the bitmap so the start slot lands at bit zero, then take the
    // lowest set bit as the offset from the start.
    assign active_dbl = {active_map_reg, active_map_reg};
    assign active_rot = active_dbl[search_start +: rrtt_pkg::SLOTS];

    always_comb
    begin
        found_off = '0;
        found_any = 1'b0;
        for (int k = rrtt_pkg::SLOTS - 1; k >= 0; k--)
        begin
            if (active_rot[k])
            begin
                found_off = rrtt_pkg::IDX_W'(k);
                found_any = 1'b1;
            end
        end
    end

    assign found_sum = {1'b0, search_start} + {1'b0, found_off};
    assign found_idx = (found_sum >= (rrtt_pkg::IDX_W + 1)'(rrtt_pkg::SLOTS))
                     ? rrtt_pkg::IDX_W'(found_sum - (rrtt_pkg::IDX_W + 1)'(rrtt_pkg::SLOTS))
                     : rrtt_pkg::IDX_W'(found_sum);

    // A slot id is valid once it has been handed out by insert.
    assign id_wide  = rrtt_pkg::CMP_W'(in_id_reg);
    assign id_valid = (id_wide < rrtt_pkg::CMP_W'(alloc_count_reg))
                   && (id_wide < rrtt_pkg::CMP_W'(rrtt_pkg::SLOTS));
    assign id_idx   = rrtt_pkg::IDX_W'(in_id_reg);

    // Command evaluation: next state and the result for this transaction.
    always_comb
    begin
        active_map_next     = active_map_reg;
        alloc_count_next    = alloc_count_reg;
        holder_index_next   = holder_index_reg;
        holder_running_next = holder_running_reg;
        saved_index_next    = saved_index_reg;
        saved_running_next  = saved_running_reg;
        result_next.is_turn = 1'b0;
        result_next.error   = rrtt_pkg::ERR_OK;

        unique case (in_cmd_reg)
            rrtt_pkg::CMD_INSERT:
            begin
                if (alloc_count_reg >= rrtt_pkg::CNT_W'(rrtt_pkg::SLOTS))
                begin
                    result_next.error = rrtt_pkg::ERR_FULL;
                end
                else
                begin
                    active_map_next[rrtt_pkg::IDX_W'(alloc_count_reg)] = 1'b1;
                    alloc_count_next = alloc_count_reg + rrtt_pkg::CNT_W'(1);
                end
            end
            rrtt_pkg::CMD_REMOVE:
            begin
                if (!id_valid)
                begin
                    result_next.error = rrtt_pkg::ERR_NOT_ALLOC;
                end
                else
                begin
                    active_map_next[id_idx] = 1'b0;
                end
            end
            rrtt_pkg::CMD_STOP:
            begin
                saved_index_next    = holder_index_reg;
                saved_running_next  = holder_running_reg;
                holder_running_next = 1'b0;
            end
            rrtt_pkg::CMD_START:
            begin
                holder_index_next   = saved_index_reg;
                holder_running_next = saved_running_reg;
            end
            rrtt_pkg::CMD_ADVANCE:
            begin
                if (!found_any)
                begin
                    result_next.error = rrtt_pkg::ERR_NONE_ACTIVE;
                end
                else
                begin
                    holder_index_next   = found_idx;
                    holder_running_next = 1'b1;
                end
            end
            rrtt_pkg::CMD_QUERY:
            begin
                if (!id_valid)
                begin
                    result_next.error = rrtt_pkg::ERR_NOT_ALLOC;
                end
                else
                begin
                    result_next.is_turn = active_map_reg[id_idx] && holder_running_reg
                                       && (holder_index_reg == id_idx);
                end
            end
            default:
            begin
                // Unused command codes only report the status.
            end
        endcase

        // A successful insert reports the new slot; everything else reports
        // the holder after the command.
        if ((in_cmd_reg == rrtt_pkg::CMD_INSERT) && (result_next.error == rrtt_pkg::ERR_OK))
        begin
            result_next.slot_out = rrtt_pkg::SLOT_W'(alloc_count_reg);
        end
        else
        begin
            result_next.slot_out = rrtt_pkg::SLOT_W'(holder_index_next);
        end
        result_next.running = holder_running_next;
    end

    // Pipeline registers: control state is reset, payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= do_work;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg <= s_tdata[rrtt_pkg::CMD_W-1:0];
            in_id_reg  <= s_tdata[rrtt_pkg::CMD_W +: rrtt_pkg::SLOT_W];
        end
        if (do_work)
        begin
            out_data_reg <= result_next;
        end
    end

    // Scheduler state, updated once per evaluated command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_map_reg     <= '0;
            alloc_count_reg    <= '0;
            holder_index_reg   <= '0;
            holder_running_reg <= 1'b0;
            saved_index_reg    <= '0;
            saved_running_reg  <= 1'b1;
        end
        else if (do_work)
        begin
            active_map_reg     <= active_map_next;
            alloc_count_reg    <= alloc_count_next;
            holder_index_reg   <= holder_index_next;
            holder_running_reg <= holder_running_next;
            saved_index_reg    <= saved_index_next;
            saved_running_reg  <= saved_running_next;
        end
    end

    // A failed advance is waiting in the result register.
    logic                              none_active_out;

    assign none_active_out = out_valid_reg
                          && (out_data_reg.error == rrtt_pkg::ERR_NONE_ACTIVE);

    // Checks on the core's own bookkeeping.
    `include "round_robin_turn_token_core_assert.svh"

    // The allocation count never passes the table size.
    `RRTT_ASSERT_IMP(a_count_bound, 1'b1, alloc_count_reg <= rrtt_pkg::CNT_W'(rrtt_pkg::SLOTS))
    // While a result waits, the running flag is the one that result reported.
    `RRTT_ASSERT_IMP(a_running_match, out_valid_reg, out_data_reg.running == holder_running_reg)
    // A failed advance means no slot was active.
    `RRTT_ASSERT_IMP(a_none_active, none_active_out, active_map_reg == '0)
    // A command held in the input register is not dropped while the output stalls.
    `RRTT_ASSERT_NEXT(a_hold_input, in_valid_reg && !out_free, in_valid_reg && $stable(in_cmd_reg))

endmodule
